// ===== rtl/gha_pkg.sv =====
// Shared types and codes for the generational handle allocator.
package gha_pkg;

    localparam logic [1:0] REQ_CREATE   = 2'd0;
    localparam logic [1:0] REQ_DESTROY  = 2'd1;
    localparam logic [1:0] REQ_VALIDATE = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  slot_index;
        logic [31:0] slot_generation;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_index;
        logic [31:0] out_generation;
        logic [8:0]  live_total;
    } t_rsp;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/gha_ctrl.sv =====
// Controller state machine: sequences the slot read and the commit of one request.
module gha_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  gha_pkg::t_sts i_sts,
    output gha_pkg::t_cmd o_cmd
);
    import gha_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_EXEC: begin
                // The result can only be committed when the output register has room.
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/gha_dp.sv =====
// Datapath: slot memory, free-list head, high-water mark, live count and result register.
module gha_dp #(
    parameter int SLOTS    = 256,
    parameter int GEN_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gha_pkg::t_req i_in,
    input  gha_pkg::t_cmd i_cmd,
    output gha_pkg::t_sts o_sts,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output gha_pkg::t_rsp o_out
);
    import gha_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PTR_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (PTR_W > 8) ? PTR_W : 8;
    // Memory word: alive flag, free link, generation.
    localparam int MW    = 1 + PTR_W + GEN_BITS;

    localparam logic [PTR_W-1:0]    NULL_LINK = PTR_W'(SLOTS);
    localparam logic [GEN_BITS-1:0] GEN_MAX   = '1;

    logic [MW-1:0] r_mem [SLOTS];

    t_req             r_req;
    logic [MW-1:0]    r_rd;
    logic [PTR_W-1:0] r_free_head;
    logic [PTR_W-1:0] r_high_water;
    logic [PTR_W-1:0] r_live_count;
    logic             r_out_valid;
    t_rsp             r_out;

    logic [PTR_W-1:0] n_free_head;
    logic [PTR_W-1:0] n_high_water;
    logic [PTR_W-1:0] n_live_count;
    t_rsp             n_out;

    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [MW-1:0]       wr_data;
    logic                head_valid;
    logic                hw_room;
    logic                handle_ok;
    logic                rd_alive;
    logic [PTR_W-1:0]    rd_link;
    logic [GEN_BITS-1:0] rd_gen;

    assign head_valid = (r_free_head != NULL_LINK);
    assign hw_room    = (r_high_water != NULL_LINK);

    // Create reads the free-list head; destroy and validate read the requested slot.
    always_comb begin
        if (i_in.req_type == REQ_CREATE) begin
            rd_addr = head_valid ? IDX_W'(r_free_head) : '0;
        end else begin
            rd_addr = IDX_W'(i_in.slot_index);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in;
            r_rd  <= r_mem[rd_addr];
        end
        if (i_cmd.commit && wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    assign rd_alive = r_rd[MW-1];
    assign rd_link  = r_rd[GEN_BITS+PTR_W-1:GEN_BITS];
    assign rd_gen   = r_rd[GEN_BITS-1:0];

    // Slots at or above the high-water mark were never written, so the range check comes first.
    assign handle_ok = (CMP_W'(r_req.slot_index) < CMP_W'(r_high_water)) && rd_alive
                       && (32'(rd_gen) == r_req.slot_generation);

    always_comb begin
        wr_en              = 1'b0;
        wr_addr            = IDX_W'(r_req.slot_index);
        wr_data            = r_rd;
        n_free_head        = r_free_head;
        n_high_water       = r_high_water;
        n_live_count       = r_live_count;
        n_out.status       = STAT_OK;
        n_out.out_index    = r_req.slot_index;
        n_out.out_generation = r_req.slot_generation;
        unique case (r_req.req_type)
            REQ_CREATE: begin
                if (head_valid) begin
                    wr_en                = 1'b1;
                    wr_addr              = IDX_W'(r_free_head);
                    wr_data              = {1'b1, NULL_LINK, rd_gen};
                    n_free_head          = rd_link;
                    n_live_count         = r_live_count + PTR_W'(1);
                    n_out.out_index      = 8'(r_free_head);
                    n_out.out_generation = 32'(rd_gen);
                end else if (hw_room) begin
                    wr_en                = 1'b1;
                    wr_addr              = IDX_W'(r_high_water);
                    wr_data              = {1'b1, NULL_LINK, {GEN_BITS{1'b0}}};
                    n_high_water         = r_high_water + PTR_W'(1);
                    n_live_count         = r_live_count + PTR_W'(1);
                    n_out.out_index      = 8'(r_high_water);
                    n_out.out_generation = '0;
                end else begin
                    n_out.status = STAT_FULL;
                end
            end
            REQ_DESTROY: begin
                if (handle_ok) begin
                    wr_en        = 1'b1;
                    n_live_count = r_live_count - PTR_W'(1);
                    if (rd_gen != GEN_MAX) begin
                        wr_data     = {1'b0, r_free_head, rd_gen + GEN_BITS'(1)};
                        n_free_head = PTR_W'(r_req.slot_index);
                    end else begin
                        // Generation exhausted: the slot is retired and never reused.
                        wr_data = {1'b0, rd_link, rd_gen};
                    end
                end else begin
                    n_out.status = STAT_INVALID;
                end
            end
            default: begin
                n_out.status = handle_ok ? STAT_OK : STAT_INVALID;
            end
        endcase
        n_out.live_total = 9'(n_live_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head  <= NULL_LINK;
            r_high_water <= '0;
            r_live_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_free_head  <= n_free_head;
                r_high_water <= n_high_water;
                r_live_count <= n_live_count;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out          = r_out;

endmodule

// ===== rtl/generational_handle_allocator_top.sv =====
// Top level of the generational handle allocator.
// A request accepted in the idle state registers itself and its slot read; its result is
// registered on the output when the output register has room, and only then is a new
// request accepted, since the slot memory is read and then written for each request.
// Reset clears the free list, high-water mark, live count and output valid; slot memory is not cleared.
module generational_handle_allocator_top #(
    parameter int SLOTS    = 256,
    parameter int GEN_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  gha_pkg::t_req i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output gha_pkg::t_rsp o_out
);
    import gha_pkg::*;

    t_cmd cmd;
    t_sts sts;

    gha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gha_dp #(
        .SLOTS    (SLOTS),
        .GEN_BITS (GEN_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
